// ===== hw/rtl/yuv2rgb_pkg.sv =====
// Shared types, register codes and color constants for the YUV 4:2:0 to RGB converter.
// No dependencies; imported by every module of the block.
package yuv2rgb_pkg;

  // Default size limits
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // Config register codes and widths
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 12;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP   = 2'd2;

  localparam logic [CFG_W-1:0] RST_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd480;

  // Width used for size compares (holds any limit up to 8192 plus one)
  localparam int SZ_W = 14;

  // Output field widths
  localparam int PIX_W = 8;
  localparam int IDX_W = 22;

  // BT.709 video-range coefficients, scaled by 65536
  localparam logic signed [18:0] K_Y  = 19'sd76309;
  localparam logic signed [18:0] K_RV = 19'sd117489;
  localparam logic signed [18:0] K_GU = 19'sd13975;
  localparam logic signed [18:0] K_GV = 19'sd34925;
  localparam logic signed [18:0] K_BU = 19'sd138438;
  localparam logic signed [8:0]  Y_OFS = 9'sd16;
  localparam logic signed [8:0]  C_OFS = 9'sd128;

  // Stage load enables of the pixel pipeline
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } pipe_ctl_t;

endpackage

// ===== hw/rtl/yuv2rgb_seq.sv =====
// Config registers and raster position counters of the YUV to RGB converter.
// Depends on yuv2rgb_pkg.
module yuv2rgb_seq #(
  parameter int MAX_WIDTH  = yuv2rgb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = yuv2rgb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [yuv2rgb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [yuv2rgb_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                  chroma_fire,
  input  logic                                  luma_fire,
  output logic [yuv2rgb_pkg::CFG_W-1:0]         w_eff,
  output logic [$clog2(MAX_WIDTH/2)-1:0]        store_waddr,
  output logic [$clog2(MAX_WIDTH/2)-1:0]        store_raddr,
  output logic [$clog2(MAX_WIDTH)-1:0]          col,
  output logic [$clog2(MAX_HEIGHT)-1:0]         orow,
  output logic                                  last
);
  import yuv2rgb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(MAX_WIDTH/2);

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic             flip;
  logic [RW-1:0]    row;
  logic [AW-1:0]    ccol;

  logic [CFG_W-1:0] h_eff;
  logic [SZ_W-1:0]  w_ext, h_ext, col_p1, row_p1, ccol_p1, orow_flip;

  // Clamp to 2..limit and force even
  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] r,
                                                input logic [SZ_W-1:0] maxv);
    logic [SZ_W-1:0] s;
    s = SZ_W'(r);
    if (s > maxv) s = maxv;
    if (s < SZ_W'(2)) s = SZ_W'(2);
    s[0] = 1'b0;
    return s[CFG_W-1:0];
  endfunction

  assign w_eff = eff_size(width_reg, SZ_W'(MAX_WIDTH));
  assign h_eff = eff_size(height_reg, SZ_W'(MAX_HEIGHT));
  assign w_ext = SZ_W'(w_eff);
  assign h_ext = SZ_W'(h_eff);

  assign col_p1    = SZ_W'(col) + SZ_W'(1);
  assign row_p1    = SZ_W'(row) + SZ_W'(1);
  assign ccol_p1   = SZ_W'(ccol) + SZ_W'(1);
  assign orow_flip = h_ext - SZ_W'(1) - SZ_W'(row);

  // Per-item tag of the current luma position
  assign orow        = flip ? orow_flip[RW-1:0] : row;
  assign last        = (SZ_W'(col) == w_ext - SZ_W'(1)) && (SZ_W'(row) == h_ext - SZ_W'(1));
  assign store_waddr = ccol;
  assign store_raddr = col[AW:1];

  // Config registers and counters; a size write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= RST_WIDTH;
      height_reg <= RST_HEIGHT;
      flip       <= 1'b1;
      col        <= '0;
      row        <= '0;
      ccol       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH: begin
          width_reg <= cfg_data;
          col       <= '0;
          row       <= '0;
          ccol      <= '0;
        end
        REG_HEIGHT: begin
          height_reg <= cfg_data;
          col        <= '0;
          row        <= '0;
          ccol       <= '0;
        end
        REG_FLIP: flip <= cfg_data[0];
        default: ;
      endcase
    end else begin
      if (chroma_fire) begin
        ccol <= (ccol_p1 >= SZ_W'(w_eff >> 1)) ? '0 : ccol_p1[AW-1:0];
      end
      if (luma_fire) begin
        if (col_p1 >= w_ext) begin
          col <= '0;
          row <= (row_p1 >= h_ext) ? '0 : row_p1[RW-1:0];
        end else begin
          col <= col_p1[CW-1:0];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/yuv2rgb_line_store.sv =====
// Chroma line store: one U/V pair per chroma column, registered read port.
// Depends on yuv2rgb_pkg (pipe_ctl_t).
module yuv2rgb_line_store #(
  parameter int MAX_WIDTH = yuv2rgb_pkg::DEF_MAX_WIDTH
) (
  input  logic                               clk,
  input  yuv2rgb_pkg::pipe_ctl_t             ctl,
  input  logic                               we,
  input  logic [$clog2(MAX_WIDTH/2)-1:0]     waddr,
  input  logic [15:0]                        wdata,
  input  logic [$clog2(MAX_WIDTH/2)-1:0]     raddr,
  output logic [15:0]                        rdata
);
  import yuv2rgb_pkg::*;

  localparam int DEPTH = MAX_WIDTH / 2;

  logic [15:0] mem [DEPTH];

  // Writes and reads come from different transactions, one per cycle, so a
  // read always sees every earlier write; no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read held while stage 1 is stalled
  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/yuv2rgb_pixel_pipe.sv =====
// Pixel pipeline: stage valids, coefficient multiplies, sum, clip and output index.
// Depends on yuv2rgb_pkg.
module yuv2rgb_pixel_pipe #(
  parameter int MAX_WIDTH  = yuv2rgb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = yuv2rgb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  luma_fire,
  input  logic [7:0]                            luma,
  input  logic [$clog2(MAX_WIDTH)-1:0]          col,
  input  logic [$clog2(MAX_HEIGHT)-1:0]         orow,
  input  logic                                  last,
  input  logic [yuv2rgb_pkg::CFG_W-1:0]         w_eff,
  input  logic [15:0]                           pair,
  input  logic                                  out_ready,
  output yuv2rgb_pkg::pipe_ctl_t                ctl,
  output logic                                  out_valid,
  output logic [yuv2rgb_pkg::PIX_W-1:0]         red,
  output logic [yuv2rgb_pkg::PIX_W-1:0]         green,
  output logic [yuv2rgb_pkg::PIX_W-1:0]         blue,
  output logic [yuv2rgb_pkg::IDX_W-1:0]         pixel_index,
  output logic                                  last_pixel
);
  import yuv2rgb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = RW + CFG_W;

  logic v1, v2;

  // Stage 1 payload
  logic [7:0]    y1;
  logic [CW-1:0] col1;
  logic [RW-1:0] orow1;
  logic          last1;

  // Stage 2 payload
  logic signed [27:0] py, prv, pgu, pgv, pbu;
  logic [PW-1:0]      pidx;
  logic [CW-1:0]      col2;
  logic               last2;

  logic signed [8:0]  ys, us, vs;
  logic signed [29:0] r_sum, g_sum, b_sum;

  // Saturate (sum >> 16) to 0..255
  function automatic logic [PIX_W-1:0] clip8(input logic signed [29:0] s);
    if (s[29]) return '0;
    if (|s[28:24]) return '1;
    return s[23:16];
  endfunction

  // Stage enables: a stage loads when it is empty or the next one loads
  assign ctl.ld3 = !out_valid || out_ready;
  assign ctl.ld2 = !v2 || ctl.ld3;
  assign ctl.ld1 = !v1 || ctl.ld2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.ld1) v1 <= luma_fire;
      if (ctl.ld2) v2 <= v1;
      if (ctl.ld3) out_valid <= v2;
    end
  end

  // Stage 1: capture sample and position; line store read lands alongside
  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      y1    <= luma;
      col1  <= col;
      orow1 <= orow;
      last1 <= last;
    end
  end

  assign ys = signed'({1'b0, y1}) - Y_OFS;
  assign us = signed'({1'b0, pair[7:0]}) - C_OFS;
  assign vs = signed'({1'b0, pair[15:8]}) - C_OFS;

  // Stage 2: coefficient products and row offset
  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      py    <= 28'(ys) * 28'(K_Y);
      prv   <= 28'(vs) * 28'(K_RV);
      pgu   <= 28'(us) * 28'(K_GU);
      pgv   <= 28'(vs) * 28'(K_GV);
      pbu   <= 28'(us) * 28'(K_BU);
      pidx  <= PW'(orow1) * PW'(w_eff);
      col2  <= col1;
      last2 <= last1;
    end
  end

  assign r_sum = 30'(py) + 30'(prv);
  assign g_sum = 30'(py) - 30'(pgu) - 30'(pgv);
  assign b_sum = 30'(py) + 30'(pbu);

  // Stage 3: sum, clip, output register
  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      red         <= clip8(r_sum);
      green       <= clip8(g_sum);
      blue        <= clip8(b_sum);
      pixel_index <= IDX_W'(pidx + PW'(col2));
      last_pixel  <= last2;
    end
  end

endmodule

// ===== hw/rtl/yuv420_to_rgb_converter.sv =====
// Top level of the YUV 4:2:0 to RGB converter (BT.709 video range).
// Depends on yuv2rgb_pkg, yuv2rgb_seq, yuv2rgb_line_store, yuv2rgb_pixel_pipe.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    action, luma, chroma_u, chroma_v
//   out      out_valid/out_ready  red, green, blue, pixel_index, last_pixel
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One input transaction per cycle while in_ready is high. A taken luma sample
// passes line store read, multiplies, sum/clip into the output register.
// A chroma transaction only writes the line store and gives no output.
// in_ready falls only when all three pipeline stages are full and out_ready
// is low. Reset clears control state only; the line store holds no reset value
// and needs no clearing pass, so items are taken from the first cycle after reset.
module yuv420_to_rgb_converter #(
  parameter int MAX_WIDTH  = yuv2rgb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = yuv2rgb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  action,
  input  logic [7:0]                            luma,
  input  logic [7:0]                            chroma_u,
  input  logic [7:0]                            chroma_v,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [yuv2rgb_pkg::PIX_W-1:0]         red,
  output logic [yuv2rgb_pkg::PIX_W-1:0]         green,
  output logic [yuv2rgb_pkg::PIX_W-1:0]         blue,
  output logic [yuv2rgb_pkg::IDX_W-1:0]         pixel_index,
  output logic                                  last_pixel,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [yuv2rgb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [yuv2rgb_pkg::CFG_W-1:0]         cfg_data
);
  import yuv2rgb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(MAX_WIDTH/2);

  pipe_ctl_t        ctl;
  logic             in_fire, chroma_fire, luma_fire;
  logic [CFG_W-1:0] w_eff;
  logic [AW-1:0]    store_waddr, store_raddr;
  logic [CW-1:0]    col;
  logic [RW-1:0]    orow;
  logic             last;
  logic [15:0]      pair;

  // Input transaction decode
  assign cfg_ready   = 1'b1;
  assign in_ready    = ctl.ld1;
  assign in_fire     = in_valid && in_ready;
  assign chroma_fire = in_fire && !action;
  assign luma_fire   = in_fire && action;

  yuv2rgb_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .chroma_fire (chroma_fire),
    .luma_fire   (luma_fire),
    .w_eff       (w_eff),
    .store_waddr (store_waddr),
    .store_raddr (store_raddr),
    .col         (col),
    .orow        (orow),
    .last        (last)
  );

  yuv2rgb_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_store (
    .clk   (clk),
    .ctl   (ctl),
    .we    (chroma_fire),
    .waddr (store_waddr),
    .wdata ({chroma_v, chroma_u}),
    .raddr (store_raddr),
    .rdata (pair)
  );

  yuv2rgb_pixel_pipe #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pipe (
    .clk         (clk),
    .rst         (rst),
    .luma_fire   (luma_fire),
    .luma        (luma),
    .col         (col),
    .orow        (orow),
    .last        (last),
    .w_eff       (w_eff),
    .pair        (pair),
    .out_ready   (out_ready),
    .ctl         (ctl),
    .out_valid   (out_valid),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .pixel_index (pixel_index),
    .last_pixel  (last_pixel)
  );

`ifndef SYNTHESIS
  // Stall at the input only when the pipeline is full behind a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  // The frame's last pixel returns the luma column to zero
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (luma_fire && last && !cfg_valid) |=> (col == '0))
    else $error("raster did not wrap after last pixel");

  // Luma column stays inside the row
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (SZ_W'(col) < SZ_W'(w_eff)))
    else $error("luma column beyond frame width");

  // Chroma write column stays inside half the row
  a_ccol_range: assert property (@(posedge clk) disable iff (rst)
    (SZ_W'(store_waddr) < SZ_W'(w_eff >> 1)))
    else $error("chroma column beyond half width");
`endif

endmodule
